// ===== src/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg
// shared types and constants for the download block deframer
// ----------------------------------------------------------------------------
package dbd_pkg;

	localparam int unsigned ADDR_W     = 24;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned TOTAL_W    = 32;
	localparam int unsigned OFFSET_W   = 17;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned FIELD_W    = 3;

	localparam logic [ADDR_W-1:0] SRAM_BASE_RST = '0;

	// count field is four bytes, block header six bytes
	localparam logic [FIELD_W-1:0] COUNT_BYTES = 3'd4;
	localparam logic [FIELD_W-1:0] HDR_SIZE_HI = 3'd4;
	localparam logic [FIELD_W-1:0] HDR_SIZE_LO = 3'd5;
	localparam logic [FIELD_W-1:0] HDR_DONE    = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_COUNT = 2'd1,
		PH_BLOCK = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ACT_COUNT = 2'd0,
		ACT_BLOCK = 2'd1,
		ACT_BYTE  = 2'd2
	} action_t;

endpackage

// ===== src/download_block_deframer.sv =====
// ----------------------------------------------------------------------------
// download_block_deframer
// deframes a serial download stream into a total count and sram byte writes
//
//  channel   signals                               direction
//  request   in_valid / in_ready, action, rx_byte  in
//  result    out_valid / out_ready, write_*,       out
//            block_done, count_done,
//            total_remaining, phase
//  config    cfg_we, cfg_data (sram_base)          in
//
//  one request per cycle; each request yields one result in the next cycle
//  state update and result are computed in one pass from the deframer state
//  the result register frees when it is empty or out_ready is high, so
//  in_ready follows it and a stall on the output holds the input side
//  arst_n clears the phase, counters and the result valid flag
// ----------------------------------------------------------------------------
module download_block_deframer
	import dbd_pkg::*;
#(
	parameter logic [ADDR_W-1:0] SramBaseRst = SRAM_BASE_RST
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ADDR_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [BYTE_W-1:0]   rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                write_valid,
	output logic [ADDR_W-1:0]   write_address,
	output logic [BYTE_W-1:0]   write_data,
	output logic                block_done,
	output logic                count_done,
	output logic [TOTAL_W-1:0]  total_remaining,
	output logic [1:0]          phase
);

	logic [ADDR_W-1:0]   sram_base_q;
	phase_t              phase_q, phase_d;
	logic [FIELD_W-1:0]  field_q, field_d;
	logic [BYTE_W-1:0]   size_hi_q, size_hi_d;
	logic [SIZE_W-1:0]   left_q, left_d;
	logic [OFFSET_W-1:0] offset_q, offset_d;
	logic [TOTAL_W-1:0]  total_q, total_d;

	logic                wv, bd, cd;
	logic [ADDR_W-1:0]   wa;
	logic [BYTE_W-1:0]   wd;
	logic [FIELD_W-1:0]  field_inc;
	logic [SIZE_W-1:0]   size_full;
	logic [SIZE_W-1:0]   left_dec;

	logic                out_valid_q;
	logic                wv_q, bd_q, cd_q;
	logic [ADDR_W-1:0]   wa_q;
	logic [BYTE_W-1:0]   wd_q;
	logic [TOTAL_W-1:0]  total_out_q;
	phase_t              phase_out_q;

	logic                accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign field_inc = field_q + 3'd1;
	assign size_full = {size_hi_q, rx_byte};
	assign left_dec  = left_q - 16'd1;

	// next state
	always_comb begin
		phase_d   = phase_q;
		field_d   = field_q;
		size_hi_d = size_hi_q;
		left_d    = left_q;
		offset_d  = offset_q;
		total_d   = total_q;
		unique case (action)
			ACT_COUNT: begin
				phase_d = PH_COUNT;
				field_d = '0;
				total_d = '0;
			end
			ACT_BLOCK: begin
				phase_d  = PH_BLOCK;
				field_d  = '0;
				offset_d = '0;
			end
			ACT_BYTE: begin
				if (phase_q == PH_COUNT) begin
					field_d = field_inc;
					total_d = {total_q[TOTAL_W-BYTE_W-1:0], rx_byte};
					if (field_inc >= COUNT_BYTES) begin
						total_d = {total_q[TOTAL_W-BYTE_W-1:0], rx_byte} - 32'd4;
						field_d = '0;
						phase_d = PH_IDLE;
					end
				end else if (phase_q == PH_BLOCK) begin
					offset_d = offset_q + 17'd1;
					total_d  = total_q - 32'd1;
					priority if (field_q < HDR_SIZE_HI) begin
						field_d = field_inc;
					end else if (field_q == HDR_SIZE_HI) begin
						size_hi_d = rx_byte;
						field_d   = field_inc;
					end else if (field_q == HDR_SIZE_LO) begin
						left_d  = size_full;
						field_d = HDR_DONE;
						if (size_full == '0) begin
							phase_d = PH_IDLE;
						end
					end else begin
						left_d = left_dec;
						if (left_dec == '0) begin
							phase_d = PH_IDLE;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result fields
	always_comb begin
		wv = 1'b0;
		wa = '0;
		wd = '0;
		bd = 1'b0;
		cd = 1'b0;
		if (action == ACT_BYTE) begin
			if (phase_q == PH_COUNT) begin
				cd = (field_inc >= COUNT_BYTES);
			end else if (phase_q == PH_BLOCK) begin
				wv = 1'b1;
				wa = sram_base_q + {{(ADDR_W-OFFSET_W){1'b0}}, offset_q};
				wd = rx_byte;
				priority if (field_q < HDR_SIZE_HI) begin
					bd = 1'b0;
				end else if (field_q == HDR_SIZE_HI) begin
					bd = 1'b0;
				end else if (field_q == HDR_SIZE_LO) begin
					bd = (size_full == '0);
				end else begin
					bd = (left_dec == '0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sram_base_q <= SramBaseRst;
		end else if (cfg_we) begin
			sram_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			field_q   <= '0;
			size_hi_q <= '0;
			left_q    <= '0;
			offset_q  <= '0;
			total_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			field_q   <= field_d;
			size_hi_q <= size_hi_d;
			left_q    <= left_d;
			offset_q  <= offset_d;
			total_q   <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wv_q        <= wv;
			wa_q        <= wa;
			wd_q        <= wd;
			bd_q        <= bd;
			cd_q        <= cd;
			total_out_q <= total_d;
			phase_out_q <= phase_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign write_valid     = wv_q;
	assign write_address   = wa_q;
	assign write_data      = wd_q;
	assign block_done      = bd_q;
	assign count_done      = cd_q;
	assign total_remaining = total_out_q;
	assign phase           = phase_out_q;

endmodule
